[src/gccg_pkg.sv]
// ----------------------------------------------------------------------------
// gccg_pkg
// Shared types, codes and default sizes for the grid cell collider gather.
// ----------------------------------------------------------------------------
package gccg_pkg;

    // Default sizes
    localparam int MAX_RESULTS_DEF   = 64;
    localparam int CELL_DEPTH_DEF    = 1024;
    localparam int LIST_DEPTH_DEF    = 4096;
    localparam int CELL_SHIFT_DEF    = 2;
    localparam int FRACTION_BITS_DEF = 8;

    // Fixed field widths
    localparam int COORD_W = 24;
    localparam int SPAN_W  = 11;
    localparam int ADDR_W  = 12;
    localparam int RANGE_W = 13;
    localparam int QUAD_W  = 15;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 2;

    // Item function codes
    localparam logic [1:0] FUNC_CELL  = 2'd0;
    localparam logic [1:0] FUNC_QUAD  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_CORNER_X = 2'd0;
    localparam logic [CFG_W-1:0] CFG_CORNER_Z = 2'd1;
    localparam logic [CFG_W-1:0] CFG_SPAN_X   = 2'd2;
    localparam logic [CFG_W-1:0] CFG_SPAN_Z   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLIP,
        S_BASE,
        S_CELL_RD,
        S_CELL_WT,
        S_MRG_RD,
        S_MRG_CMP,
        S_NEXT,
        S_OUT_RD,
        S_OUT_WT,
        S_OUT_HOLD
    } t_state;

endpackage

[src/gccg_ram.sv]
// ----------------------------------------------------------------------------
// gccg_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module gccg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/grid_cell_collider_gather.sv]
// ----------------------------------------------------------------------------
// grid_cell_collider_gather
// Uniform-grid broad-phase query: merges the quad lists of all covered cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one item per transfer. Func
//   CELL writes a start/end pair into the cell table, func QUAD writes one
//   entry of the quad list; both give no result.
//   Func QUERY takes a box, walks every covered cell in X-major order and
//   merges each cell's list into a running ascending union held in two
//   ping-pong buffer RAMs, then streams the union out.
//   Output channel (o_valid / i_ready) gives one index per transfer; last
//   marks the final one. An empty query gives a single result, found low.
//   Steps: the box is clipped (S_CLIP), the row base formed (S_BASE);
//   each covered cell is read (S_CELL_RD, S_CELL_WT), a non-empty list
//   merged with the running union up to MAX_RESULTS (S_MRG_RD waits on
//   the registered buffer and list RAM reads, S_MRG_CMP writes), and
//   stepped (S_NEXT); each result is read (S_OUT_RD, S_OUT_WT) and held.
//   One item is in work at a time: o_ready is high only when idle.
//   A stalled receiver simply holds the output register; nothing is lost.
//   Reset (synchronous, active low) clears control state and the registers;
//   the tables are undefined until written. CELL_DEPTH must be a power of
//   two: the cell address wraps by truncation.
// ----------------------------------------------------------------------------
module grid_cell_collider_gather
    import gccg_pkg::*;
#(
    parameter int MAX_RESULTS   = MAX_RESULTS_DEF,
    parameter int CELL_DEPTH    = CELL_DEPTH_DEF,
    parameter int LIST_DEPTH    = LIST_DEPTH_DEF,
    parameter int CELL_SHIFT    = CELL_SHIFT_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_addr,
    input  logic [COORD_W-1:0]        i_cfg_wdata,
    // input items
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_func,
    input  logic [ADDR_W-1:0]         i_table_addr,
    input  logic [RANGE_W-1:0]        i_range_start,
    input  logic [RANGE_W-1:0]        i_range_end,
    input  logic [QUAD_W-1:0]         i_quad_entry,
    input  logic signed [COORD_W-1:0] i_box_min_x,
    input  logic signed [COORD_W-1:0] i_box_max_x,
    input  logic signed [COORD_W-1:0] i_box_min_z,
    input  logic signed [COORD_W-1:0] i_box_max_z,
    // results
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [QUAD_W-1:0]         o_collider_index,
    output logic                      o_last,
    output logic                      o_found,
    output logic                      o_overflow,
    output logic [COUNT_W-1:0]        o_total_count
);

    localparam int CAW  = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int LAW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int BAW  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int CW   = $clog2(MAX_RESULTS + 1);
    localparam int SH   = CELL_SHIFT + FRACTION_BITS;
    localparam int DW   = COORD_W + 1;      // coordinate difference width
    localparam int PW   = 2 * SPAN_W;       // cell address accumulator width
    localparam int JW   = 17;               // list position width
    localparam int CDW  = 2 * RANGE_W;      // cell table entry width
    localparam logic [JW-1:0] CELL_LIM = JW'(CELL_DEPTH);
    localparam logic [JW-1:0] LIST_LIM = JW'(LIST_DEPTH);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_RESULTS);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [COORD_W-1:0] r_corner_x, r_corner_z;
    logic [SPAN_W-1:0]  r_span_x, r_span_z;

    logic signed [DW-1:0] r_cx0, r_cx1, r_cz0, r_cz1;
    logic signed [DW-1:0] n_cx0, n_cx1, n_cz0, n_cz1;
    logic [SPAN_W-1:0]    r_x, r_z, n_x, n_z;
    logic [PW-1:0]        r_xbase, n_xbase;
    logic [JW-1:0]        r_j, r_jend, n_j, n_jend;
    logic [CW-1:0]        r_i, r_n, r_count, n_i, n_n, n_count;
    logic                 r_sel, r_cut, n_sel, n_cut;

    logic                 r_out_valid, n_out_valid;
    logic [QUAD_W-1:0]    r_out_idx, n_out_idx;
    logic                 r_out_last, n_out_last;
    logic                 r_out_found, n_out_found;
    logic                 r_out_ovf, n_out_ovf;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic             cell_we, list_we, buf0_we, buf1_we;
    logic [JW-1:0]    tab_addr_w;
    logic [CDW-1:0]   cell_rdata;
    logic [QUAD_W-1:0] list_rdata, buf0_rdata, buf1_rdata, buf_rdata, merge_val;
    logic [PW-1:0]    cell_sum;
    logic [CAW-1:0]   cell_raddr;
    logic [BAW-1:0]   buf_raddr, buf_waddr;

    assign tab_addr_w = JW'(i_table_addr);
    assign cell_sum   = r_xbase + PW'(r_z);
    assign cell_raddr = cell_sum[CAW-1:0];
    assign buf_raddr  = r_i[BAW-1:0];
    assign buf_waddr  = r_n[BAW-1:0];
    assign buf_rdata  = r_sel ? buf1_rdata : buf0_rdata;

    gccg_ram #(.WIDTH(CDW), .DEPTH(CELL_DEPTH)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (tab_addr_w[CAW-1:0]),
        .i_wdata ({i_range_start, i_range_end}),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    gccg_ram #(.WIDTH(QUAD_W), .DEPTH(LIST_DEPTH)) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (tab_addr_w[LAW-1:0]),
        .i_wdata (i_quad_entry),
        .i_raddr (r_j[LAW-1:0]),
        .o_rdata (list_rdata)
    );

    // Ping-pong union buffers: read the current one, build into the other
    gccg_ram #(.WIDTH(QUAD_W), .DEPTH(MAX_RESULTS)) u_buf0_ram (
        .i_clk   (i_clk),
        .i_we    (buf0_we),
        .i_waddr (buf_waddr),
        .i_wdata (merge_val),
        .i_raddr (buf_raddr),
        .o_rdata (buf0_rdata)
    );

    gccg_ram #(.WIDTH(QUAD_W), .DEPTH(MAX_RESULTS)) u_buf1_ram (
        .i_clk   (i_clk),
        .i_we    (buf1_we),
        .i_waddr (buf_waddr),
        .i_wdata (merge_val),
        .i_raddr (buf_raddr),
        .o_rdata (buf1_rdata)
    );

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_x <= '0;
            r_corner_z <= '0;
            r_span_x   <= SPAN_W'(1);
            r_span_z   <= SPAN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CORNER_X: r_corner_x <= i_cfg_wdata;
                CFG_CORNER_Z: r_corner_z <= i_cfg_wdata;
                CFG_SPAN_X:   r_span_x   <= i_cfg_wdata[SPAN_W-1:0];
                CFG_SPAN_Z:   r_span_z   <= i_cfg_wdata[SPAN_W-1:0];
                default:      r_span_z   <= r_span_z;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                 in_xfer;
    logic signed [DW-1:0] dx0, dx1, dz0, dz1;
    logic signed [DW-1:0] cx0_c, cx1_c, cz0_c, cz1_c, lim_x, lim_z;
    logic [JW-1:0]        cell_s, cell_e, cell_ec;
    logic                 i_ok, j_ok, take_a, take_b;

    assign in_xfer = i_valid && o_ready;

    // Floor of the offset over the cell size: an arithmetic shift
    assign dx0 = (DW'(i_box_min_x) - DW'($signed(r_corner_x))) >>> SH;
    assign dx1 = (DW'(i_box_max_x) - DW'($signed(r_corner_x))) >>> SH;
    assign dz0 = (DW'(i_box_min_z) - DW'($signed(r_corner_z))) >>> SH;
    assign dz1 = (DW'(i_box_max_z) - DW'($signed(r_corner_z))) >>> SH;

    assign lim_x = $signed(DW'(r_span_x));
    assign lim_z = $signed(DW'(r_span_z));
    assign cx0_c = (r_cx0 < 0) ? '0 : r_cx0;
    assign cz0_c = (r_cz0 < 0) ? '0 : r_cz0;
    assign cx1_c = (r_cx1 >= lim_x) ? lim_x - DW'(1) : r_cx1;
    assign cz1_c = (r_cz1 >= lim_z) ? lim_z - DW'(1) : r_cz1;

    assign cell_s  = JW'(cell_rdata[CDW-1:RANGE_W]);
    assign cell_e  = JW'(cell_rdata[RANGE_W-1:0]);
    assign cell_ec = (cell_e > LIST_LIM) ? LIST_LIM : cell_e;

    assign i_ok = r_i < r_count;
    assign j_ok = r_j < r_jend;

    // Merge step: equal heads emit once and advance both
    always_comb begin
        take_a = 1'b0;
        take_b = 1'b0;
        if (i_ok && j_ok) begin
            take_a = buf_rdata <= list_rdata;
            take_b = list_rdata <= buf_rdata;
        end else if (i_ok) begin
            take_a = 1'b1;
        end else begin
            take_b = 1'b1;
        end
        merge_val = take_a ? buf_rdata : list_rdata;
    end

    // ------------------------------------------------------------------
    // Memory control
    // ------------------------------------------------------------------
    always_comb begin
        cell_we = in_xfer && (i_func == FUNC_CELL) && (tab_addr_w < CELL_LIM);
        list_we = in_xfer && (i_func == FUNC_QUAD) && (tab_addr_w < LIST_LIM);
        buf0_we = (r_state == S_MRG_CMP) && r_sel;
        buf1_we = (r_state == S_MRG_CMP) && !r_sel;
    end

    // ------------------------------------------------------------------
    // Next state and datapath
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_cx0       = r_cx0;
        n_cx1       = r_cx1;
        n_cz0       = r_cz0;
        n_cz1       = r_cz1;
        n_x         = r_x;
        n_z         = r_z;
        n_xbase     = r_xbase;
        n_j         = r_j;
        n_jend      = r_jend;
        n_i         = r_i;
        n_n         = r_n;
        n_count     = r_count;
        n_sel       = r_sel;
        n_cut       = r_cut;
        n_out_valid = r_out_valid;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        n_out_found = r_out_found;
        n_out_ovf   = r_out_ovf;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_func == FUNC_QUERY)) begin
                    n_cx0   = dx0;
                    n_cx1   = dx1;
                    n_cz0   = dz0;
                    n_cz1   = dz1;
                    n_count = '0;
                    n_cut   = 1'b0;
                    n_state = S_CLIP;
                end
            end
            S_CLIP: begin
                // Clip to the grid; an inverted range covers nothing
                n_cx0 = cx0_c;
                n_cx1 = cx1_c;
                n_cz0 = cz0_c;
                n_cz1 = cz1_c;
                if ((cx0_c > cx1_c) || (cz0_c > cz1_c)) begin
                    n_i     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                n_x     = r_cx0[SPAN_W-1:0];
                n_z     = r_cz0[SPAN_W-1:0];
                n_xbase = r_cx0[SPAN_W-1:0] * r_span_x;
                n_state = S_CELL_RD;
            end
            S_CELL_RD: begin
                n_state = S_CELL_WT;
            end
            S_CELL_WT: begin
                if (cell_s < cell_ec) begin
                    n_j     = cell_s;
                    n_jend  = cell_ec;
                    n_i     = '0;
                    n_n     = '0;
                    n_state = S_MRG_RD;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_MRG_RD: begin
                if (!i_ok && !j_ok) begin
                    n_count = r_n;
                    n_sel   = !r_sel;
                    n_state = S_NEXT;
                end else if (r_n == MAX_CNT) begin
                    // Buffer full with input left: cut the union here
                    n_cut   = 1'b1;
                    n_count = r_n;
                    n_sel   = !r_sel;
                    n_state = S_NEXT;
                end else begin
                    n_state = S_MRG_CMP;
                end
            end
            S_MRG_CMP: begin
                n_n = r_n + CW'(1);
                if (take_a) begin
                    n_i = r_i + CW'(1);
                end
                if (take_b) begin
                    n_j = r_j + JW'(1);
                end
                n_state = S_MRG_RD;
            end
            S_NEXT: begin
                if (r_z == r_cz1[SPAN_W-1:0]) begin
                    n_z = r_cz0[SPAN_W-1:0];
                    if (r_x == r_cx1[SPAN_W-1:0]) begin
                        n_i     = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_x     = r_x + SPAN_W'(1);
                        n_xbase = r_xbase + PW'(r_span_x);
                        n_state = S_CELL_RD;
                    end
                end else begin
                    n_z     = r_z + SPAN_W'(1);
                    n_state = S_CELL_RD;
                end
            end
            S_OUT_RD: begin
                if (r_count == '0) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = '0;
                    n_out_last  = 1'b1;
                    n_out_found = 1'b0;
                    n_out_ovf   = 1'b0;
                    n_state     = S_OUT_HOLD;
                end else begin
                    n_state = S_OUT_WT;
                end
            end
            S_OUT_WT: begin
                n_out_valid = 1'b1;
                n_out_idx   = buf_rdata;
                n_out_last  = (r_i + CW'(1)) == r_count;
                n_out_found = 1'b1;
                n_out_ovf   = r_cut;
                n_state     = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                // Hold the result until the receiver takes it
                if (i_ready) begin
                    n_out_valid = 1'b0;
                    n_i         = r_i + CW'(1);
                    n_state     = r_out_last ? S_IDLE : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_cut       <= 1'b0;
            r_sel       <= 1'b0;
            r_i         <= '0;
            r_n         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_cut       <= n_cut;
            r_sel       <= n_sel;
            r_i         <= n_i;
            r_n         <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx0       <= n_cx0;
        r_cx1       <= n_cx1;
        r_cz0       <= n_cz0;
        r_cz1       <= n_cz1;
        r_x         <= n_x;
        r_z         <= n_z;
        r_xbase     <= n_xbase;
        r_j         <= n_j;
        r_jend      <= n_jend;
        r_out_idx   <= n_out_idx;
        r_out_last  <= n_out_last;
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_collider_index = r_out_idx;
    assign o_last           = r_out_last;
    assign o_found          = r_out_found;
    assign o_overflow       = r_out_ovf;
    assign o_total_count    = COUNT_W'(r_count);

endmodule

[tb/grid_cell_collider_gather_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_collider_gather_checker
// Watches both channels of the grid gather, mirrors the cell table and quad
// list, computes the merged index list of each query and compares results.
// ----------------------------------------------------------------------------
module grid_cell_collider_gather_checker
    import gccg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_addr,
    input  logic [COORD_W-1:0]        i_cfg_wdata,
    input  logic                      i_valid,
    input  logic                      i_ready_in,
    input  logic [1:0]                i_func,
    input  logic [ADDR_W-1:0]         i_table_addr,
    input  logic [RANGE_W-1:0]        i_range_start,
    input  logic [RANGE_W-1:0]        i_range_end,
    input  logic [QUAD_W-1:0]         i_quad_entry,
    input  logic signed [COORD_W-1:0] i_box_min_x,
    input  logic signed [COORD_W-1:0] i_box_max_x,
    input  logic signed [COORD_W-1:0] i_box_min_z,
    input  logic signed [COORD_W-1:0] i_box_max_z,
    input  logic                      i_res_valid,
    input  logic                      i_res_ready,
    input  logic [QUAD_W-1:0]         i_collider_index,
    input  logic                      i_last,
    input  logic                      i_found,
    input  logic                      i_overflow,
    input  logic [COUNT_W-1:0]        i_total_count,
    output int                        o_errors,
    output int                        o_pending
);

    typedef struct packed {
        logic [QUAD_W-1:0]  idx;
        logic               last;
        logic               found;
        logic               ovf;
        logic [COUNT_W-1:0] total;
    } t_hit;

    logic signed [COORD_W-1:0] corner_x, corner_z;
    logic [SPAN_W-1:0]         span_x, span_z;
    logic [RANGE_W-1:0]        cell_lo [CELL_DEPTH_DEF];
    logic [RANGE_W-1:0]        cell_hi [CELL_DEPTH_DEF];
    logic [QUAD_W-1:0]         quads   [LIST_DEPTH_DEF];
    t_hit                      hits_due[$];

    assign o_pending = hits_due.size();

    function automatic longint cell_coord(logic signed [COORD_W-1:0] c,
                                          logic signed [COORD_W-1:0] org);
        longint d;
        d = longint'(c) - longint'(org);
        return d >>> (CELL_SHIFT_DEF + FRACTION_BITS_DEF);
    endfunction

    // Build the merged union for one box and queue its results
    task automatic gather_box();
        logic [QUAD_W-1:0] acc[$];
        logic [QUAD_W-1:0] nxt[$];
        longint x0, x1, z0, z1, gx, gz;
        int     s, e, i, j, addr;
        bit     cut;
        t_hit   h;
        x0 = cell_coord(i_box_min_x, corner_x);
        x1 = cell_coord(i_box_max_x, corner_x);
        z0 = cell_coord(i_box_min_z, corner_z);
        z1 = cell_coord(i_box_max_z, corner_z);
        cut = 0;
        if (x0 < 0) x0 = 0;
        if (z0 < 0) z0 = 0;
        if (x1 > longint'(span_x) - 1) x1 = longint'(span_x) - 1;
        if (z1 > longint'(span_z) - 1) z1 = longint'(span_z) - 1;
        for (gx = x0; gx <= x1; gx++) begin
            for (gz = z0; gz <= z1; gz++) begin
                addr = int'((gx * longint'(span_x) + gz) % CELL_DEPTH_DEF);
                s = cell_lo[addr];
                e = cell_hi[addr];
                if (e > LIST_DEPTH_DEF) e = LIST_DEPTH_DEF;
                if (s >= e) continue;
                nxt = {};
                i = 0;
                j = s;
                while (i < acc.size() || j < e) begin
                    if (nxt.size() >= MAX_RESULTS_DEF) begin
                        cut = 1;
                        break;
                    end
                    if (i < acc.size() && j < e) begin
                        if (acc[i] == quads[j]) begin
                            nxt.push_back(acc[i]); i++; j++;
                        end else if (acc[i] < quads[j]) begin
                            nxt.push_back(acc[i]); i++;
                        end else begin
                            nxt.push_back(quads[j]); j++;
                        end
                    end else if (i < acc.size()) begin
                        nxt.push_back(acc[i]); i++;
                    end else begin
                        nxt.push_back(quads[j]); j++;
                    end
                end
                acc = nxt;
            end
        end
        if (acc.size() == 0) begin
            h = '{idx: '0, last: 1'b1, found: 1'b0, ovf: 1'b0, total: '0};
            hits_due.push_back(h);
        end else begin
            foreach (acc[k]) begin
                h.idx   = acc[k];
                h.last  = (k == acc.size() - 1);
                h.found = 1'b1;
                h.ovf   = cut;
                h.total = COUNT_W'(acc.size());
                hits_due.push_back(h);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n) begin
            corner_x <= '0;
            corner_z <= '0;
            span_x   <= SPAN_W'(1);
            span_z   <= SPAN_W'(1);
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CORNER_X: corner_x <= i_cfg_wdata;
                    CFG_CORNER_Z: corner_z <= i_cfg_wdata;
                    CFG_SPAN_X:   span_x   <= i_cfg_wdata[SPAN_W-1:0];
                    default:      span_z   <= i_cfg_wdata[SPAN_W-1:0];
                endcase
            end
            if (i_valid && i_ready_in) begin
                case (i_func)
                    FUNC_CELL: begin
                        if (i_table_addr < CELL_DEPTH_DEF) begin
                            cell_lo[i_table_addr] = i_range_start;
                            cell_hi[i_table_addr] = i_range_end;
                        end
                    end
                    FUNC_QUAD: quads[i_table_addr] = i_quad_entry;
                    FUNC_QUERY: gather_box();
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (hits_due.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected result index %0d", $realtime,
                                 i_collider_index);
                    o_errors <= o_errors + 1;
                end else begin
                    want = hits_due.pop_front();
                    if (want != {i_collider_index, i_last, i_found, i_overflow,
                                 i_total_count}) begin
                        if (o_errors < 10)
                            $display("%0t: mismatch exp idx=%0d last=%0b found=%0b ovf=%0b tot=%0d got idx=%0d last=%0b found=%0b ovf=%0b tot=%0d",
                                     $realtime, want.idx, want.last, want.found, want.ovf,
                                     want.total, i_collider_index, i_last, i_found,
                                     i_overflow, i_total_count);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/grid_cell_collider_gather_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_collider_gather_tb
// Loads cell tables and quad lists, fires directed and random box queries
// under several grid settings with random gaps and stalls on both sides;
// the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module grid_cell_collider_gather_tb;
    import gccg_pkg::*;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_W-1:0]          i_cfg_addr = '0;
    logic [COORD_W-1:0]        i_cfg_wdata = '0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [1:0]                i_func = FUNC_CELL;
    logic [ADDR_W-1:0]         i_table_addr = '0;
    logic [RANGE_W-1:0]        i_range_start = '0;
    logic [RANGE_W-1:0]        i_range_end = '0;
    logic [QUAD_W-1:0]         i_quad_entry = '0;
    logic signed [COORD_W-1:0] i_box_min_x = '0;
    logic signed [COORD_W-1:0] i_box_max_x = '0;
    logic signed [COORD_W-1:0] i_box_min_z = '0;
    logic signed [COORD_W-1:0] i_box_max_z = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [QUAD_W-1:0]         o_collider_index;
    logic                      o_last;
    logic                      o_found;
    logic                      o_overflow;
    logic [COUNT_W-1:0]        o_total_count;
    int                        fail_count;
    int                        hits_waiting;
    int                        hold_off = 0;

    // Mirror of the occupied grid so queries land on written cells only
    logic signed [COORD_W-1:0] org_x, org_z;
    int                        sx, sz;
    int                        list_top;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    grid_cell_collider_gather i_dut (.*);

    grid_cell_collider_gather_checker i_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .i_valid, .i_ready_in(o_ready), .i_func, .i_table_addr,
        .i_range_start, .i_range_end, .i_quad_entry,
        .i_box_min_x, .i_box_max_x, .i_box_min_z, .i_box_max_z,
        .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_collider_index(o_collider_index), .i_last(o_last), .i_found(o_found),
        .i_overflow(o_overflow), .i_total_count(o_total_count),
        .o_errors(fail_count), .o_pending(hits_waiting)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(3, 30);
    endfunction

    // Receiver: random stalls, plus one long hold-off requested by stimulus
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready  <= 1'b0;
        end else if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 9) < 6);
        end
    end

    // Offer one item and hold it until the transfer; drop valid only for a gap
    task automatic send(logic [1:0] f, int addr, int rs, int re, int q,
                        int bx0, int bx1, int bz0, int bz1);
        int g;
        i_valid       <= 1'b1;
        i_func        <= f;
        i_table_addr  <= ADDR_W'(addr);
        i_range_start <= RANGE_W'(rs);
        i_range_end   <= RANGE_W'(re);
        i_quad_entry  <= QUAD_W'(q);
        i_box_min_x   <= COORD_W'(bx0);
        i_box_max_x   <= COORD_W'(bx1);
        i_box_min_z   <= COORD_W'(bz0);
        i_box_max_z   <= COORD_W'(bz1);
        do @(posedge i_clk); while (!(i_valid && o_ready));
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(logic [CFG_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= COORD_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Wait for the block to drain before touching registers
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (hits_waiting != 0 || !o_ready) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Set grid registers and fill every reachable cell with an ascending list
    task automatic setup_grid(int cx, int cz, int nx, int nz, int minlen, int maxlen,
                              int ncells);
        int n, v, c;
        drain();
        cfg_write(CFG_CORNER_X, cx);
        cfg_write(CFG_CORNER_Z, cz);
        cfg_write(CFG_SPAN_X, nx);
        cfg_write(CFG_SPAN_Z, nz);
        org_x = COORD_W'(cx);
        org_z = COORD_W'(cz);
        sx = nx;
        sz = nz;
        list_top = 0;
        // every cell an address can reach is written, so nothing undefined is read
        for (c = 0; c < CELL_DEPTH_DEF && c < ncells; c++) begin
            n = $urandom_range(minlen, maxlen);
            if (list_top + n > LIST_DEPTH_DEF) n = 0;
            v = $urandom_range(0, 40);
            for (int k = 0; k < n; k++) begin
                send(FUNC_QUAD, list_top + k, 0, 0, v, 0, 0, 0, 0);
                v = v + $urandom_range(1, 60);
                if (v > 32767) v = 32767 - (n - k);
            end
            send(FUNC_CELL, c, list_top, list_top + n, 0, 0, 0, 0, 0);
            list_top += n;
        end
    endtask

    // Query a box of random cell extent inside or around the grid
    task automatic query_cells(int wx, int wz);
        int ax, az, bx, bz;
        ax = $urandom_range(0, sx + 1) - 1;
        az = $urandom_range(0, sz + 1) - 1;
        bx = ax + $urandom_range(0, wx);
        bz = az + $urandom_range(0, wz);
        send(FUNC_QUERY, 0, 0, 0, 0,
             int'(org_x) + ax * 1024 + $urandom_range(0, 1023),
             int'(org_x) + bx * 1024 + $urandom_range(0, 1023),
             int'(org_z) + az * 1024 + $urandom_range(0, 1023),
             int'(org_z) + bz * 1024 + $urandom_range(0, 1023));
    endtask

    initial begin
        int rnx, rnz;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: small grid at origin with full-range corners afterwards
        setup_grid(0, 0, 3, 3, 0, 4, 9);
        send(FUNC_QUERY, 0, 0, 0, 0, 0, 16383, 0, 16383);
        send(FUNC_QUERY, 0, 0, 0, 0, 4096, 0, 0, 4096);
        send(FUNC_QUERY, 0, 0, 0, 0, -8388608, 8388607, -8388608, 8388607);
        send(FUNC_QUERY, 0, 0, 0, 0, 8388607, 8388607, 8388607, 8388607);
        send(FUNC_QUERY, 0, 0, 0, 0, -8388608, -1, -8388608, -1);
        send(FUNC_QUERY, 0, 0, 0, 0, -1, 0, -1, 0);
        // func 3 and out-of-range writes are dropped
        send(2'd3, 4095, 8191, 8191, 32767, -1, -1, -1, -1);
        send(FUNC_CELL, 4095, 8191, 8191, 0, 0, 0, 0, 0);
        // inverted and clipped-end cell ranges
        send(FUNC_CELL, 0, 10, 5, 0, 0, 0, 0, 0);
        send(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
        send(FUNC_CELL, 0, 4090, 8191, 0, 0, 0, 0, 0);
        for (int k = 4090; k < 4096; k++)
            send(FUNC_QUAD, k, 0, 0, 32767 - 4095 + k, 0, 0, 0, 0);
        send(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
        // unsorted list
        send(FUNC_QUAD, 4090, 0, 0, 32767, 0, 0, 0, 0);
        send(FUNC_QUAD, 4091, 0, 0, 0, 0, 0, 0, 0);
        send(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);

        // Long hold-off on the receiver while items keep coming
        hold_off = 400;
        for (int k = 0; k < 6; k++) query_cells(3, 3);
        for (int k = 0; k < 8; k++) query_cells(2, 2);

        // Overflow: one cell with a list longer than the result limit
        setup_grid(-8388608, 8388607 - 20 * 1024, 1, 1, 65, 67, 1);
        for (int k = 0; k < 12; k++) query_cells(2, 2);

        // Maximum X span; the address wraps modulo the cell depth onto z
        setup_grid(8388607 - 1024 * 1024, -8388608, 1024, 2, 0, 3, 2);
        for (int k = 0; k < 10; k++) query_cells(2, 2);

        // Random grid
        rnx = $urandom_range(1, 3);
        rnz = $urandom_range(1, 3);
        setup_grid(int'($urandom) >>> 8, int'($urandom) >>> 8,
                   rnx, rnz, 0, 3, (rnx - 1) * rnx + rnz);
        for (int k = 0; k < 12; k++) query_cells(3, 3);

        drain();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
src/gccg_pkg.sv
src/gccg_ram.sv
src/grid_cell_collider_gather.sv
tb/grid_cell_collider_gather_checker.sv
tb/grid_cell_collider_gather_tb.sv
